// ----- rtl/itt_pkg.sv -----
// shared types and constants of the text tokenizer
package itt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam longint unsigned MAX_TOKEN_LEN = 64'd65535;
   localparam logic [15:0] LEN_CAP =
      (MAX_TOKEN_LEN < 64'd65535) ? 16'(MAX_TOKEN_LEN) : 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_SLASH   = 3'd2,
      MODE_MINUS   = 3'd3,
      MODE_WORD    = 3'd4
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_PUNCT = 2'd0,
      KIND_ARROW = 2'd1,
      KIND_WORD  = 2'd2
   } token_kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] start;
      logic [15:0] length;
      logic        saturated;
      logic [31:0] line;
      logic [7:0]  first;
      logic [31:0] index;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

endpackage

// ----- rtl/itt_scanner.sv -----
// input register, scan state and per-byte token logic
module itt_scanner
   import itt_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_input,
   input  logic       room,
   output push_type   push
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LOW_P  = 8'h70;
   localparam logic [7:0] CH_UP_P   = 8'h50;

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   function automatic logic is_single(input logic [7:0] b);
      return b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE ||
             b == CH_LBRACK || b == CH_RBRACK || b == CH_COMMA || b == CH_COLON ||
             b == CH_EQUALS || b == CH_PLUS || b == CH_MINUS;
   endfunction

   function automatic logic is_sign(input logic [7:0] b);
      return b == CH_PLUS || b == CH_MINUS;
   endfunction

   // bytes that end a word whatever came before
   function automatic logic is_hard_break(input logic [7:0] b);
      return is_space(b) || b == CH_HASH || (is_single(b) && !is_sign(b));
   endfunction

   // input register
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_eoi_ff;
   logic       fire;
   logic       accept;

   // scan state
   scan_mode_type            mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [31:0]              line_ff, line_in;
   logic [OFFSET_BITS-1:0]   wstart_ff, wstart_in;
   logic [15:0]              wlen_ff, wlen_in;
   logic                     numeric_ff, numeric_in;
   logic [7:0]               wfirst_ff, wfirst_in;
   logic [7:0]               prev_ff, prev_in;
   logic [31:0]              tokens_ff, tokens_in;
   logic                     ovf_ff, ovf_in;

   token_type  tok_a, tok_b;
   logic       tok_a_v, tok_b_v;
   logic       idle_go;
   logic [7:0] b;
   logic [1:0] n;

   assign fire      = stage_valid_ff && room;
   assign req_stall = stage_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_byte_ff <= req_char_byte;
         stage_eoi_ff  <= req_end_of_input;
      end
   end

   always_comb begin
      b          = stage_byte_ff;
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      wstart_in  = wstart_ff;
      wlen_in    = wlen_ff;
      numeric_in = numeric_ff;
      wfirst_in  = wfirst_ff;
      prev_in    = prev_ff;
      ovf_in     = ovf_ff;
      tok_a      = '0;
      tok_b      = '0;
      tok_a_v    = 1'b0;
      tok_b_v    = 1'b0;
      idle_go    = 1'b0;

      // pending token or word continuation
      if (stage_eoi_ff) begin
         unique case (mode_ff)
            MODE_WORD: begin
               tok_a_v = 1'b1;
               tok_a.kind = KIND_WORD;
               tok_a.start = 32'(wstart_ff);
               tok_a.length = wlen_ff;
               tok_a.saturated = ovf_ff;
               tok_a.first = wfirst_ff;
            end
            MODE_SLASH: begin
               tok_a_v = 1'b1;
               tok_a.kind = KIND_WORD;
               tok_a.start = 32'(wstart_ff);
               tok_a.length = 16'd1;
               tok_a.first = CH_SLASH;
            end
            MODE_MINUS: begin
               tok_a_v = 1'b1;
               tok_a.kind = KIND_PUNCT;
               tok_a.start = 32'(wstart_ff);
               tok_a.length = 16'd1;
               tok_a.first = CH_MINUS;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
      end else begin
         prev_in = b;
         pos_in  = pos_ff + OFFSET_BITS'(1);
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (b == CH_LF) begin
                  line_in = line_ff + 32'd1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else if (is_hard_break(b) || is_sign(b)) begin
                  // a lone slash is a one-byte word
                  tok_a_v = 1'b1;
                  tok_a.kind = KIND_WORD;
                  tok_a.start = 32'(wstart_ff);
                  tok_a.length = 16'd1;
                  tok_a.first = CH_SLASH;
                  idle_go = 1'b1;
               end else begin
                  mode_in    = MODE_WORD;
                  wlen_in    = 16'd2;
                  wfirst_in  = CH_SLASH;
                  numeric_in = 1'b0;
                  ovf_in     = 1'b0;
               end
            end
            MODE_MINUS: begin
               tok_a_v = 1'b1;
               tok_a.start = 32'(wstart_ff);
               tok_a.first = CH_MINUS;
               if (b == CH_GT) begin
                  tok_a.kind = KIND_ARROW;
                  tok_a.length = 16'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  tok_a.kind = KIND_PUNCT;
                  tok_a.length = 16'd1;
                  idle_go = 1'b1;
               end
            end
            MODE_WORD: begin
               // sign stays in a numeric word after an exponent letter
               if (is_hard_break(b) || (is_sign(b) && !(numeric_ff &&
                   (prev_ff == CH_LOW_E || prev_ff == CH_UP_E ||
                    prev_ff == CH_LOW_P || prev_ff == CH_UP_P)))) begin
                  tok_a_v = 1'b1;
                  tok_a.kind = KIND_WORD;
                  tok_a.start = 32'(wstart_ff);
                  tok_a.length = wlen_ff;
                  tok_a.saturated = ovf_ff;
                  tok_a.first = wfirst_ff;
                  idle_go = 1'b1;
               end else if (wlen_ff < LEN_CAP) begin
                  wlen_in = wlen_ff + 16'd1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
               idle_go = 1'b1;
            end
         endcase
      end

      // byte seen between tokens
      if (idle_go) begin
         mode_in = MODE_IDLE;
         priority if (is_space(b)) begin
            if (b == CH_LF) begin
               line_in = line_ff + 32'd1;
            end
         end else if (b == CH_HASH) begin
            mode_in = MODE_COMMENT;
         end else if (b == CH_SLASH) begin
            wstart_in = pos_ff;
            mode_in   = MODE_SLASH;
         end else if (b == CH_MINUS) begin
            wstart_in = pos_ff;
            mode_in   = MODE_MINUS;
         end else if (is_single(b)) begin
            tok_b_v = 1'b1;
            tok_b.kind = KIND_PUNCT;
            tok_b.start = 32'(pos_ff);
            tok_b.length = 16'd1;
            tok_b.first = b;
         end else begin
            wstart_in  = pos_ff;
            wlen_in    = 16'd1;
            ovf_in     = 1'b0;
            wfirst_in  = b;
            numeric_in = (b == CH_DOT) || (b >= CH_ZERO && b <= CH_NINE);
            mode_in    = MODE_WORD;
         end
      end

      n = {1'b0, tok_a_v} + {1'b0, tok_b_v};
      tokens_in = tokens_ff + 32'(n);

      push.count = fire ? n : 2'd0;
      push.tok0 = tok_a_v ? tok_a : tok_b;
      push.tok0.line = line_ff;
      push.tok0.index = tokens_ff;
      push.tok0.last = !(tok_a_v && tok_b_v);
      push.tok1 = tok_b;
      push.tok1.line = line_ff;
      push.tok1.index = tokens_ff + 32'd1;
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pos_ff     <= '0;
         line_ff    <= 32'd1;
         wstart_ff  <= '0;
         wlen_ff    <= '0;
         numeric_ff <= 1'b0;
         wfirst_ff  <= '0;
         prev_ff    <= '0;
         tokens_ff  <= '0;
         ovf_ff     <= 1'b0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         wstart_ff  <= wstart_in;
         wlen_ff    <= wlen_in;
         numeric_ff <= numeric_in;
         wfirst_ff  <= wfirst_in;
         prev_ff    <= prev_in;
         tokens_ff  <= tokens_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

// ----- rtl/itt_rsp_queue.sv -----
// small result queue, up to two pushes and one pop a cycle
module itt_rsp_queue
   import itt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      room,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output token_type rsp_tok
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   token_type       entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;
   logic [PtrW-1:0] wr_ptr_next;

   // room for two more results
   assign room      = count_ff <= CntW'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_tok   = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.tok1;
      end
   end

endmodule

// ----- rtl/ir_text_tokenizer_top.sv -----
// top level of the streaming text tokenizer
//
// req_ carries one source byte per transaction, or an end marker
// (req_end_of_input high) that flushes a pending word, '/' or '-'.
// rsp_ carries one token per transaction; a byte can cause zero, one or
// two tokens, and rsp_last_of_run marks the final token of a byte.
// A byte is taken into an input register; the scan logic then runs
// combinationally from that register into a four-entry result queue,
// written when the queue has room for two tokens, and tokens are offered
// from the queue. One byte is accepted every cycle as long as the queue
// has room for two tokens; sustained output is one token per cycle while
// rsp_stall is low, set by the single read port of the result queue.
// When rsp_stall is held, the queue fills and req_stall rises; results
// wait in the queue unchanged and nothing is lost.
// Reset (synchronous, active high) empties the queue, sets the byte
// offset, token count and word state to zero and the line count to one.
module ir_text_tokenizer_top
   import itt_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_length_saturated,
   output logic [31:0] rsp_token_line,
   output logic [7:0]  rsp_first_char,
   output logic [31:0] rsp_token_index,
   output logic        rsp_last_of_run
);

   push_type  push;
   logic      room;
   token_type rsp_tok;

   itt_scanner #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scanner (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .room             (room),
      .push             (push)
   );

   itt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tok   (rsp_tok)
   );

   assign rsp_token_kind       = rsp_tok.kind;
   assign rsp_token_start      = rsp_tok.start;
   assign rsp_token_length     = rsp_tok.length;
   assign rsp_length_saturated = rsp_tok.saturated;
   assign rsp_token_line       = rsp_tok.line;
   assign rsp_first_char       = rsp_tok.first;
   assign rsp_token_index      = rsp_tok.index;
   assign rsp_last_of_run      = rsp_tok.last;

endmodule

// ----- tb/ir_text_tokenizer_checker.sv -----
// checker for the text tokenizer: predicts tokens from accepted bytes and compares results
module ir_text_tokenizer_checker
   import itt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_token_kind,
   input  logic [31:0] rsp_token_start,
   input  logic [15:0] rsp_token_length,
   input  logic        rsp_length_saturated,
   input  logic [31:0] rsp_token_line,
   input  logic [7:0]  rsp_first_char,
   input  logic [31:0] rsp_token_index,
   input  logic        rsp_last_of_run,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // scanner state as the block should hold it
   scan_mode_type mode;
   logic [31:0]   pos;
   logic [31:0]   line;
   logic [31:0]   wstart;
   logic [15:0]   wlen;
   logic          wnum;
   logic          wsat;
   logic [7:0]    wfirst;
   logic [7:0]    prev;
   logic [31:0]   tok_count;

   token_type     tokens_due[$];
   token_type     held_tok;
   bit            have_tok = 1'b0;
   int unsigned   fail_count = 0;

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic bit is_single(logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]" ||
             c == "," || c == ":" || c == "=" || c == "+" || c == "-";
   endfunction

   task automatic queue_token(token_type t);
      tokens_due = {tokens_due, t};
   endtask

   // the last token of a transaction is held back so it can be flagged
   task automatic emit_token(token_kind_type k, logic [31:0] s, logic [15:0] l,
                             logic sat, logic [7:0] f);
      token_type t;
      t.kind      = k;
      t.start     = s;
      t.length    = l;
      t.saturated = sat;
      t.line      = line;
      t.first     = f;
      t.index     = tok_count;
      t.last      = 1'b0;
      if (have_tok) queue_token(held_tok);
      held_tok  = t;
      have_tok  = 1'b1;
      tok_count = tok_count + 32'd1;
   endtask

   task automatic open_word(logic [31:0] s, logic [7:0] c);
      wstart = s;
      wlen   = 16'd1;
      wsat   = 1'b0;
      wfirst = c;
      wnum   = (c == "." || (c >= "0" && c <= "9"));
      mode   = MODE_WORD;
   endtask

   task automatic idle_char(logic [7:0] c);
      mode = MODE_IDLE;
      if (is_blank(c)) begin
         if (c == CH_LF) line = line + 32'd1;
      end else if (c == "#") begin
         mode = MODE_COMMENT;
      end else if (c == "/") begin
         wstart = pos;
         mode   = MODE_SLASH;
      end else if (c == "-") begin
         wstart = pos;
         mode   = MODE_MINUS;
      end else if (is_single(c)) begin
         emit_token(KIND_PUNCT, pos, 16'd1, 1'b0, c);
      end else begin
         open_word(pos, c);
      end
   endtask

   // prev still holds the byte before c here
   task automatic word_char(logic [7:0] c);
      bit brk;
      brk = is_blank(c) || c == "#" || (is_single(c) && c != "+" && c != "-");
      if (!brk && (c == "+" || c == "-"))
         brk = !((prev == "e" || prev == "E" || prev == "p" || prev == "P") && wnum);
      if (brk) begin
         emit_token(KIND_WORD, wstart, wlen, wsat, wfirst);
         idle_char(c);
      end else if (wlen < LEN_CAP) begin
         wlen = wlen + 16'd1;
      end else begin
         wsat = 1'b1;
      end
   endtask

   task automatic predict_tokens(logic eoi, logic [7:0] c);
      if (eoi) begin
         case (mode)
            MODE_WORD:  emit_token(KIND_WORD, wstart, wlen, wsat, wfirst);
            MODE_SLASH: emit_token(KIND_WORD, wstart, 16'd1, 1'b0, "/");
            MODE_MINUS: emit_token(KIND_PUNCT, wstart, 16'd1, 1'b0, "-");
            default: ;
         endcase
         mode = MODE_IDLE;
      end else begin
         case (mode)
            MODE_COMMENT: begin
               if (c == CH_LF) begin
                  line = line + 32'd1;
                  mode = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (c == "/") begin
                  mode = MODE_COMMENT;
               end else begin
                  open_word(wstart, "/");
                  word_char(c);
               end
            end
            MODE_MINUS: begin
               if (c == ">") begin
                  emit_token(KIND_ARROW, wstart, 16'd2, 1'b0, "-");
                  mode = MODE_IDLE;
               end else begin
                  emit_token(KIND_PUNCT, wstart, 16'd1, 1'b0, "-");
                  idle_char(c);
               end
            end
            MODE_WORD: word_char(c);
            default:   idle_char(c);
         endcase
         prev = c;
         pos  = pos + 32'd1;
      end
      if (have_tok) begin
         held_tok.last = 1'b1;
         queue_token(held_tok);
         have_tok = 1'b0;
      end
   endtask

   task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: token %s expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   task automatic check_token();
      token_type want;
      if (tokens_due.size() == 0) begin
         $display("%0t: unexpected token, expected none, actual start %0d length %0d",
                  $time, rsp_token_start, rsp_token_length);
         fail_count++;
      end else begin
         want = tokens_due.pop_front();
         compare_field("kind", 32'(want.kind), 32'(rsp_token_kind));
         compare_field("start", want.start, rsp_token_start);
         compare_field("length", 32'(want.length), 32'(rsp_token_length));
         compare_field("saturated", 32'(want.saturated), 32'(rsp_length_saturated));
         compare_field("line", want.line, rsp_token_line);
         compare_field("first_char", 32'(want.first), 32'(rsp_first_char));
         compare_field("index", want.index, rsp_token_index);
         compare_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode      = MODE_IDLE;
         pos       = '0;
         line      = 32'd1;
         wstart    = '0;
         wlen      = '0;
         wnum      = 1'b0;
         wsat      = 1'b0;
         wfirst    = '0;
         prev      = '0;
         tok_count = '0;
         have_tok  = 1'b0;
         tokens_due.delete();
      end else begin
         if (req_valid && !req_stall) predict_tokens(req_end_of_input, req_char_byte);
         if (rsp_valid && !rsp_stall) check_token();
      end
      mismatches  <= fail_count;
      outstanding <= unsigned'(tokens_due.size());
   end

endmodule

// ----- tb/tb_ir_text_tokenizer_top.sv -----
// testbench top for the text tokenizer: clock, reset, byte stimulus and verdict
module tb_ir_text_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import itt_pkg::*;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_%@$";
   localparam string DIGITS  = "0123456789";
   localparam string ALNUM   = "abcdefgxyzEPep0123456789._";
   localparam string SINGLES = "(){}[],:=+-";
   localparam string BLANKS  = " \t\015\n";

   typedef struct packed {
      logic       eoi;
      logic [7:0] ch;
   } text_unit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_token_kind;
   logic [31:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_length_saturated;
   logic [31:0] rsp_token_line;
   logic [7:0]  rsp_first_char;
   logic [31:0] rsp_token_index;
   logic        rsp_last_of_run;

   int unsigned   mismatches;
   int unsigned   outstanding;
   bit            long_hold = 1'b0;
   text_unit_type text_q[$];

   always #5 clock = ~clock;

   ir_text_tokenizer_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_char_byte        (req_char_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_token_start      (rsp_token_start),
      .rsp_token_length     (rsp_token_length),
      .rsp_length_saturated (rsp_length_saturated),
      .rsp_token_line       (rsp_token_line),
      .rsp_first_char       (rsp_first_char),
      .rsp_token_index      (rsp_token_index),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   ir_text_tokenizer_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_char_byte        (req_char_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_token_start      (rsp_token_start),
      .rsp_token_length     (rsp_token_length),
      .rsp_length_saturated (rsp_length_saturated),
      .rsp_token_line       (rsp_token_line),
      .rsp_first_char       (rsp_first_char),
      .rsp_token_index      (rsp_token_index),
      .rsp_last_of_run      (rsp_last_of_run),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   function automatic logic [7:0] pick_from(string set);
      return 8'(set[$urandom_range(0, set.len() - 1)]);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 50);
   endfunction

   function automatic int pick_hold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_char(logic [7:0] c);
      text_unit_type u;
      u.eoi  = 1'b0;
      u.ch   = c;
      text_q = {text_q, u};
   endtask

   task automatic push_end();
      text_unit_type u;
      u.eoi  = 1'b1;
      u.ch   = 8'($urandom_range(0, 255));
      text_q = {text_q, u};
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(8'(s[i]));
   endtask

   task automatic push_ident();
      push_char(pick_from(LETTERS));
      repeat ($urandom_range(0, 6)) push_char(pick_from(ALNUM));
   endtask

   // one lexical piece of text, mostly well formed, some noise
   task automatic add_fragment();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         push_ident();
      end else if (sel < 40) begin
         push_char(($urandom_range(0, 4) == 0) ? 8'(".") : pick_from(DIGITS));
         repeat ($urandom_range(0, 3)) push_char(pick_from(DIGITS));
         if ($urandom_range(0, 1)) begin
            push_char(pick_from("eEpP"));
            if ($urandom_range(0, 3) != 0) push_char(pick_from("+-"));
            repeat ($urandom_range(0, 2)) push_char(pick_from(DIGITS));
         end
      end else if (sel < 50) begin
         push_ident();
         push_char(pick_from("+-"));
         push_ident();
      end else if (sel < 62) begin
         push_char(pick_from(SINGLES));
      end else if (sel < 68) begin
         push_text("->");
      end else if (sel < 72) begin
         push_char("-");
         push_char(8'($urandom_range(0, 255)));
      end else if (sel < 76) begin
         push_char("/");
         push_char(8'($urandom_range(0, 255)));
      end else if (sel < 82) begin
         if ($urandom_range(0, 1)) push_char("#");
         else push_text("//");
         repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(0, 255)));
         push_char(CH_LF);
      end else if (sel < 92) begin
         push_char(pick_from(BLANKS));
      end else if (sel < 95) begin
         push_end();
      end else begin
         push_char(8'($urandom_range(0, 255)));
      end
      if (sel < 50 && $urandom_range(0, 1)) push_char(pick_from(BLANKS));
   endtask

   // called at a rising edge; returns at the edge after the gap
   task automatic send_unit(text_unit_type u, int gap);
      req_valid        <= 1'b1;
      req_end_of_input <= u.eoi;
      req_char_byte    <= u.ch;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic play_text(bit gappy);
      text_unit_type u;
      while (text_q.size() > 0) begin
         u = text_q.pop_front();
         send_unit(u, gappy ? pick_gap() : 0);
      end
   endtask

   task automatic wait_drained(int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // result side: random open and stall stretches, one long hold on request
   initial begin : rx_side
      int hold;
      forever begin
         rsp_stall <= 1'b0;
         repeat (1 + (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3)))
            @(posedge clock);
         if (long_hold) begin
            hold = 400;
            long_hold = 1'b0;
         end else begin
            hold = pick_hold();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int rand_units;
      rand_units = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every punctuation, arrow, minus and slash lookahead, comments, exponents
      push_text("(){}[],:=+->-a /b //c\n");
      push_text("#x\n\015\t1e+5 .5P-2 x-y e+");
      push_char(8'hFF);
      push_char(8'h00);
      push_end();
      push_char("/");
      push_end();
      push_char("-");
      push_end();
      push_char("#");
      push_end();
      push_end();
      push_text("-->");
      push_end();
      play_text(1'b1);
      wait_drained(4);

      // receiver holds off while bytes keep coming
      long_hold = 1'b1;
      while (text_q.size() < 120) begin
         push_char(pick_from(SINGLES));
         add_fragment();
      end
      wait (!long_hold);
      play_text(1'b0);
      wait_drained(4);

      while (rand_units < 1100) begin
         repeat ($urandom_range(10, 40)) add_fragment();
         rand_units += text_q.size();
         play_text($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 5) == 0) wait_drained(4);
      end

      wait_drained(20);
      if (mismatches == 0)
         $display("ir_text_tokenizer_top: match");
      else
         $display("ir_text_tokenizer_top: mismatch");
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("ir_text_tokenizer_top: mismatch");
      $finish;
   end

endmodule
